// ----- hdl/wpfd_pkg.sv -----
// Shared types and constants for the pulse frame decoder.
package wpfd_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned FrameBits = 24;
  localparam int unsigned BitCntW   = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned QueueDepth = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegResetGap = 3'd0;
  localparam logic [CfgIdxW-1:0] RegZeroMin  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegZeroMax  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneMin   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOneMax   = 3'd4;

  localparam logic StatusFrame = 1'b0;
  localparam logic StatusError = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_BAD  = 2'd2
  } pulse_cls_e;

  // one classified pulse, front to back
  typedef struct packed {
    logic       start;
    pulse_cls_e cls;
  } pulse_t;

  // one decoded result
  typedef struct packed {
    logic                 status;
    logic [ByteW-1:0]     third_byte;
    logic [ByteW-1:0]     second_byte;
    logic [ByteW-1:0]     first_byte;
  } result_t;

endpackage

// ----- hdl/wpfd_front.sv -----
// Front end: configuration registers, gap/width arithmetic and pulse classification.
module wpfd_front import wpfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TimeW-1:0]   rise_time_i,
  input  logic [TimeW-1:0]   fall_time_i,
  output logic               push_o,
  output pulse_t             pulse_o,
  input  logic               q_ready_i
);

  logic [CfgW-1:0]  reset_gap_q, zero_min_q, zero_max_q, one_min_q, one_max_q;
  logic [TimeW-1:0] last_fall_q;
  logic [TimeW-1:0] gap, width;
  logic             in_zero, in_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_gap_q <= 16'd2400;
      zero_min_q  <= 16'd10;
      zero_max_q  <= 16'd28;
      one_min_q   <= 16'd29;
      one_max_q   <= 16'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegResetGap: reset_gap_q <= cfg_wdata_i;
        RegZeroMin:  zero_min_q  <= cfg_wdata_i;
        RegZeroMax:  zero_max_q  <= cfg_wdata_i;
        RegOneMin:   one_min_q   <= cfg_wdata_i;
        RegOneMax:   one_max_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fall_q <= '0;
    end else if (push_o) begin
      last_fall_q <= fall_time_i;
    end
  end

  // both differences wrap modulo 2^32
  assign gap   = rise_time_i - last_fall_q;
  assign width = fall_time_i - rise_time_i;

  assign in_zero = (width >= TimeW'(zero_min_q)) && (width <= TimeW'(zero_max_q));
  assign in_one  = (width >= TimeW'(one_min_q))  && (width <= TimeW'(one_max_q));

  always_comb begin
    pulse_o.start = gap > TimeW'(reset_gap_q);
    if (in_zero) begin
      pulse_o.cls = CLS_ZERO;
    end else if (in_one) begin
      pulse_o.cls = CLS_ONE;
    end else begin
      pulse_o.cls = CLS_BAD;
    end
  end

endmodule

// ----- hdl/wpfd_fifo.sv -----
// Short queue of classified pulses between front and back.
module wpfd_fifo import wpfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  pulse_t wdata_i,
  output logic   ready_o,
  output logic   valid_o,
  input  logic   pop_i,
  output pulse_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pulse_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign ready_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !ready_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

// ----- hdl/wpfd_back.sv -----
// Back end: frame tracking, bit assembly and the output register.
module wpfd_back import wpfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  pulse_t  q_data_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic                 in_frame_q;
  logic [BitCntW-1:0]   bits_taken_q;
  logic [FrameBits-1:0] bit_shift_q;
  logic                 out_valid_q;
  result_t              out_q;

  logic                 frame_eff;
  logic [BitCntW-1:0]   bits_eff, bits_n;
  logic [FrameBits-1:0] shift_eff, shift_n;
  logic                 emit;
  result_t              res;
  logic                 in_frame_d;
  logic [BitCntW-1:0]   bits_taken_d;
  logic [FrameBits-1:0] bit_shift_d;

  // a waiting result blocks the back only while the sink stalls
  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    frame_eff = in_frame_q || q_data_i.start;
    bits_eff  = q_data_i.start ? '0 : bits_taken_q;
    shift_eff = q_data_i.start ? '0 : bit_shift_q;
    shift_n   = {shift_eff[FrameBits-2:0], q_data_i.cls == CLS_ONE};
    bits_n    = bits_eff + 1'b1;

    emit         = 1'b0;
    res          = '0;
    in_frame_d   = frame_eff;
    bits_taken_d = bits_eff;
    bit_shift_d  = shift_eff;

    if (frame_eff) begin
      case (q_data_i.cls)
        CLS_ZERO, CLS_ONE: begin
          if (bits_n == BitCntW'(FrameBits)) begin
            emit             = 1'b1;
            res.first_byte   = shift_n[3*ByteW-1:2*ByteW];
            res.second_byte  = shift_n[2*ByteW-1:ByteW];
            res.third_byte   = shift_n[ByteW-1:0];
            res.status       = StatusFrame;
            in_frame_d       = 1'b0;
            bits_taken_d     = '0;
            bit_shift_d      = '0;
          end else begin
            bits_taken_d = bits_n;
            bit_shift_d  = shift_n;
          end
        end
        default: begin
          emit         = 1'b1;
          res.status   = StatusError;
          in_frame_d   = 1'b0;
          bits_taken_d = '0;
          bit_shift_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bits_taken_q <= '0;
      bit_shift_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        in_frame_q   <= in_frame_d;
        bits_taken_q <= bits_taken_d;
        bit_shift_q  <= bit_shift_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_taken_q < BitCntW'(FrameBits)) else $error("bit count past frame length");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (bits_taken_q == '0 && bit_shift_q == '0))
    else $error("stale frame state outside a frame");
  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i) |=> (out_valid_q == $past(pop_o && emit)))
    else $error("result appeared without a pulse");
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == StatusError) |->
      (out_q.first_byte == '0 && out_q.second_byte == '0 && out_q.third_byte == '0))
    else $error("error result carries data");

endmodule

// ----- hdl/ws2812_pulse_frame_decoder.sv -----
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/s_axis_tready  tdata: rise_time[31:0], fall_time[63:32]
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata: 3 colour bytes; tuser: status
// cfg        in   cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i[15:0]
//
// One pulse per cycle while the queue has room; the front classifies at acceptance
// and the back retires one queue entry per cycle unless its result is stalled.
// m_axis_tvalid comes from the output register past the queue. Reset clears the queue,
// timestamps and frame state and loads register defaults. A stalled sink holds the
// output register; the queue absorbs QDepth pulses before s_axis_tready drops.
module ws2812_pulse_frame_decoder import wpfd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // rise_time[31:0], fall_time[63:32]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // first_byte[7:0], second_byte[15:8],
                                             // third_byte[23:16]
  output logic               m_axis_tuser    // status[0]
);

  logic    push, q_ready, q_valid, pop;
  pulse_t  pulse_in, pulse_out;
  result_t result;

  wpfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rise_time_i (s_axis_tdata[31:0]),
    .fall_time_i (s_axis_tdata[63:32]),
    .push_o      (push),
    .pulse_o     (pulse_in),
    .q_ready_i   (q_ready)
  );

  wpfd_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (pulse_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (pulse_out)
  );

  wpfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pulse_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {result.third_byte, result.second_byte, result.first_byte};
  assign m_axis_tuser = result.status;

endmodule
